[rtl/cubic_point_to_point_trajectory_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the cubic point-to-point trajectory core
// Concurrent checks written through these macros so they can be compiled out.
// ----------------------------------------------------------------------------
`ifndef CUBIC_POINT_TO_POINT_TRAJECTORY_CORE_ASSERT_SVH
`define CUBIC_POINT_TO_POINT_TRAJECTORY_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication check, disabled during reset
`define CPTP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("cptp assertion failed");
// Next-cycle implication check, disabled during reset
`define CPTP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) ante |=> cons) \
        else $error("cptp assertion failed");
`else
`define CPTP_ASSERT(lbl, clk, rstn, prop)
`define CPTP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[rtl/cptp_pkg.sv]
// ----------------------------------------------------------------------------
// cptp_pkg
// Types, constants and helper functions of the trajectory core.
// ----------------------------------------------------------------------------
package cptp_pkg;

    localparam int AXES_DEF = 3;
    localparam int FRAC_DEF = 16;
    localparam int NUM_AXES = 3;
    localparam int AXIS_W   = 2;
    localparam int ADDR_W   = 5;

    // Register indexes
    localparam logic [2:0] REG_TARGET_X = 3'd0;
    localparam logic [2:0] REG_TARGET_Y = 3'd1;
    localparam logic [2:0] REG_TARGET_Z = 3'd2;
    localparam logic [2:0] REG_ACCEL_X  = 3'd3;
    localparam logic [2:0] REG_ACCEL_Y  = 3'd4;
    localparam logic [2:0] REG_ACCEL_Z  = 3'd5;
    localparam logic [2:0] REG_TICK     = 3'd6;

    // tau fixed point: 30 fraction bits
    localparam logic [63:0] TAU_ONE   = 64'd1 << 30;
    localparam logic [63:0] S_COEF    = 64'd3 << 30;
    localparam logic [34:0] E_MID     = 35'd6 << 30;

    typedef logic signed [31:0] s32_t;

    typedef struct packed {
        logic func;
        s32_t meas_x;
        s32_t meas_y;
        s32_t meas_z;
    } in_item_t;

    typedef struct packed {
        s32_t pos_x;
        s32_t pos_y;
        s32_t pos_z;
        s32_t vel_x;
        s32_t vel_y;
        s32_t vel_z;
        s32_t acc_x;
        s32_t acc_y;
        s32_t acc_z;
        logic all_done;
    } out_item_t;

    typedef struct packed {
        s32_t [NUM_AXES-1:0]        target;
        logic [NUM_AXES-1:0][30:0]  accel;
        logic [16:0]                tick;
    } cfg_t;

    // Micro-operations sequenced by the controller
    typedef enum logic [3:0] {
        U_LATCH = 4'd0,
        U_QDIV  = 4'd1,
        U_SQRT  = 4'd2,
        U_CHECK = 4'd3,
        U_TAU   = 4'd4,
        U_TAU2  = 4'd5,
        U_S     = 4'd6,
        U_U     = 4'd7,
        U_P     = 4'd8,
        U_VM    = 4'd9,
        U_VD    = 4'd10,
        U_TT    = 4'd11,
        U_AM    = 4'd12,
        U_AD    = 4'd13,
        U_WR    = 4'd14
    } uop_t;

    // Iterative arithmetic unit operations
    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_DIVP = 2'd2,
        OP_SQRT = 2'd3
    } op_t;

    typedef struct packed {
        logic              accept;
        logic              push;
        logic              issue;
        uop_t              uop;
        logic [AXIS_W-1:0] axis;
    } ctrl_cmd_t;

    typedef struct packed {
        logic arith_done;
        logic active;
        logic running;
    } dp_stat_t;

    function automatic logic is_arith(input uop_t u);
        is_arith = !(u == U_LATCH || u == U_CHECK || u == U_WR);
    endfunction

    // Saturate a 36-bit two's complement value to 32 bits
    function automatic logic [31:0] sat_s32(input logic [35:0] v);
        if (!v[35] && v[34:31] != 4'h0) begin
            sat_s32 = 32'h7FFF_FFFF;
        end else if (v[35] && v[34:31] != 4'hF) begin
            sat_s32 = 32'h8000_0000;
        end else begin
            sat_s32 = v[31:0];
        end
    endfunction

    // Apply a sign to a magnitude and saturate to 32 signed bits
    function automatic logic [31:0] signed_mag(input logic neg, input logic [63:0] mag);
        logic big;
        big = (mag[63:31] != '0);
        if (neg) begin
            signed_mag = big ? 32'h8000_0000 : (32'd0 - mag[31:0]);
        end else begin
            signed_mag = big ? 32'h7FFF_FFFF : mag[31:0];
        end
    endfunction

endpackage

[rtl/cptp_regs.sv]
// ----------------------------------------------------------------------------
// cptp_regs
// APB-style configuration registers: targets, peak accelerations, tick period.
// ----------------------------------------------------------------------------
module cptp_regs #(
    parameter int FRAC_BITS = cptp_pkg::FRAC_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cptp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output cptp_pkg::cfg_t              cfg
);
    import cptp_pkg::*;

    localparam logic [30:0] ACCEL_RST = 31'(64'd1 << FRAC_BITS);
    localparam logic [16:0] TICK_RST  = 17'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);

    cfg_t        cfg_reg;
    logic        wr_en;
    logic [2:0]  idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[ADDR_W-1:2];
    assign cfg    = cfg_reg;

    // Write registers on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target <= '0;
            cfg_reg.accel  <= {NUM_AXES{ACCEL_RST}};
            cfg_reg.tick   <= TICK_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_TARGET_X: cfg_reg.target[0] <= pwdata;
                REG_TARGET_Y: cfg_reg.target[1] <= pwdata;
                REG_TARGET_Z: cfg_reg.target[2] <= pwdata;
                REG_ACCEL_X:  cfg_reg.accel[0]  <= pwdata[30:0];
                REG_ACCEL_Y:  cfg_reg.accel[1]  <= pwdata[30:0];
                REG_ACCEL_Z:  cfg_reg.accel[2]  <= pwdata[30:0];
                REG_TICK:     cfg_reg.tick      <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (idx)
            REG_TARGET_X: prdata = cfg_reg.target[0];
            REG_TARGET_Y: prdata = cfg_reg.target[1];
            REG_TARGET_Z: prdata = cfg_reg.target[2];
            REG_ACCEL_X:  prdata = {1'b0, cfg_reg.accel[0]};
            REG_ACCEL_Y:  prdata = {1'b0, cfg_reg.accel[1]};
            REG_ACCEL_Z:  prdata = {1'b0, cfg_reg.accel[2]};
            REG_TICK:     prdata = {15'd0, cfg_reg.tick};
            default:      prdata = '0;
        endcase
    end

endmodule

[rtl/cptp_arith.sv]
// ----------------------------------------------------------------------------
// cptp_arith
// Shared iterative unit: 64x64 shift-add multiply, 128/64 restoring divide
// and 64-bit integer square root, one bit (or bit pair) per cycle.
// ----------------------------------------------------------------------------
`include "cubic_point_to_point_trajectory_core_assert.svh"
module cptp_arith (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  cptp_pkg::op_t   op,
    input  logic [63:0]     a,
    input  logic [63:0]     b,
    output logic            done,
    output logic [63:0]     acc_hi,
    output logic [63:0]     acc_lo
);
    import cptp_pkg::*;

    logic [63:0] hi_reg, lo_reg, opb_reg;
    logic [5:0]  cnt_reg;
    op_t         op_reg;
    logic        busy_reg, done_reg;

    logic [64:0] msum;
    logic [63:0] dh, dl, rb;
    logic        dsub;

    assign done   = done_reg;
    assign acc_hi = hi_reg;
    assign acc_lo = lo_reg;

    // One iteration of each operation
    always_comb begin
        msum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, opb_reg} : 65'd0);
        dh   = {hi_reg[62:0], lo_reg[63]};
        dl   = {lo_reg[62:0], 1'b0};
        dsub = hi_reg[63] || (dh >= opb_reg);
        rb   = hi_reg + opb_reg;
    end

    // Control: busy flag, counter, done pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_MUL;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                op_reg   <= op;
                cnt_reg  <= (op == OP_SQRT) ? 6'd31 : 6'd63;
                if ((op == OP_DIVP && hi_reg >= b) || (op == OP_DIV && b == '0)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 6'd1;
                end
            end
        end
    end

    // Operand and accumulator registers
    always_ff @(posedge aclk) begin
        if (start) begin
            unique case (op)
                OP_MUL: begin
                    hi_reg  <= '0;
                    lo_reg  <= b;
                    opb_reg <= a;
                end
                OP_DIV: begin
                    hi_reg  <= '0;
                    lo_reg  <= (b == '0) ? '1 : a;
                    opb_reg <= b;
                end
                OP_DIVP: begin
                    opb_reg <= b;
                    if (hi_reg >= b) lo_reg <= '1;
                end
                OP_SQRT: begin
                    hi_reg  <= '0;
                    lo_reg  <= a;
                    opb_reg <= 64'd1 << 62;
                end
                default: ;
            endcase
        end else if (busy_reg) begin
            unique case (op_reg)
                OP_MUL: begin
                    hi_reg <= msum[64:1];
                    lo_reg <= {msum[0], lo_reg[63:1]};
                end
                OP_DIV, OP_DIVP: begin
                    hi_reg <= dsub ? (dh - opb_reg) : dh;
                    lo_reg <= {dl[63:1], dsub};
                end
                OP_SQRT: begin
                    if (lo_reg >= rb) begin
                        lo_reg <= lo_reg - rb;
                        hi_reg <= (hi_reg >> 1) + opb_reg;
                    end else begin
                        hi_reg <= hi_reg >> 1;
                    end
                    opb_reg <= opb_reg >> 2;
                end
                default: ;
            endcase
        end
    end

    `CPTP_ASSERT(a_start_when_free, aclk, aresetn, start |-> !busy_reg)
    `CPTP_ASSERT(a_done_after_busy, aclk, aresetn, done_reg |-> !busy_reg)
    `CPTP_ASSERT_NEXT(a_busy_no_done, aclk, aresetn, busy_reg && cnt_reg != '0, !done_reg)

endmodule

[rtl/cptp_dp.sv]
// ----------------------------------------------------------------------------
// cptp_dp
// Datapath: trajectory state, operand selection for the shared arithmetic
// unit, per-axis result registers and the output register.
// ----------------------------------------------------------------------------
module cptp_dp #(
    parameter int AXES      = cptp_pkg::AXES_DEF,
    parameter int FRAC_BITS = cptp_pkg::FRAC_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cptp_pkg::ctrl_cmd_t cmd,
    output cptp_pkg::dp_stat_t  stat,
    input  cptp_pkg::cfg_t      cfg,
    input  cptp_pkg::in_item_t  s_data,
    output cptp_pkg::out_item_t m_data
);
    import cptp_pkg::*;

    localparam logic [63:0] OFF_Q   = ((64'd325 << FRAC_BITS) + 64'd5000) / 64'd10000;
    localparam int          ACC_SH  = 30 - FRAC_BITS;
    localparam int          Q_LIM   = 64 - FRAC_BITS;

    // Trajectory state
    logic [31:0] start_reg [AXES];
    logic [31:0] dur_reg   [AXES];
    logic [31:0] elap_reg  [AXES];
    logic        running_reg;

    // Work registers
    in_item_t    item_reg;
    logic [63:0] q_reg, tt_reg;
    logic [30:0] tau_reg, s_reg, u_reg;
    logic [31:0] opos_reg [NUM_AXES];
    logic [31:0] ovel_reg [NUM_AXES];
    logic [31:0] oacc_reg [NUM_AXES];
    logic        alld_reg;
    out_item_t   m_data_reg;

    // Arithmetic unit hookup
    logic        ar_start, ar_done;
    op_t         ar_op;
    logic [63:0] ar_a, ar_b, ar_hi, ar_lo;

    logic [AXIS_W-1:0] ax;
    logic [31:0] tgt, st, tt, dd, meas;
    logic [33:0] d, dabs, mpos;
    logic [31:0] mag;
    logic        neg, active;
    logic [34:0] mag6, tau12, emag;
    logic        eneg;
    logic [63:0] mag6_f, magf, den_a;
    logic [35:0] pos_sum;
    logic [33:0] pterm;
    logic [32:0] elap_sum;

    assign ax = cmd.axis;

    // Per-axis operands
    always_comb begin
        tgt    = cfg.target[ax];
        st     = start_reg[ax];
        tt     = elap_reg[ax];
        dd     = dur_reg[ax];
        d      = {{2{tgt[31]}}, tgt} - {{2{st[31]}}, st};
        neg    = d[33];
        dabs   = neg ? (34'd0 - d) : d;
        mag    = dabs[31:0];
        active = (tt <= dd) && (dd != '0);
        mag6   = {1'b0, mag, 2'b00} + {2'b00, mag, 1'b0};
        mag6_f = 64'(mag6) << FRAC_BITS;
        magf   = 64'(mag) << FRAC_BITS;
        den_a  = (cfg.accel[ax] == '0) ? 64'd1 : 64'(cfg.accel[ax]);
        tau12  = {1'b0, tau_reg, 3'b000} + {2'b00, tau_reg, 2'b00};
        eneg   = tau12 > E_MID;
        emag   = eneg ? (tau12 - E_MID) : (E_MID - tau12);
        unique case (ax)
            2'd0:    meas = item_reg.meas_x;
            2'd1:    meas = item_reg.meas_y;
            default: meas = item_reg.meas_z;
        endcase
        // Start point with the fixed x/y offset
        if (ax == 2'd0) begin
            mpos = {{2{meas[31]}}, meas} - OFF_Q[33:0];
        end else if (ax == 2'd1) begin
            mpos = {{2{meas[31]}}, meas} + OFF_Q[33:0];
        end else begin
            mpos = {{2{meas[31]}}, meas};
        end
        pterm    = ar_lo[63:30];
        pos_sum  = {{4{st[31]}}, st} + (neg ? (36'd0 - 36'(pterm)) : 36'(pterm));
        elap_sum = {1'b0, tt} + 33'(cfg.tick);
    end

    // Select the arithmetic operation for each step
    always_comb begin
        ar_op = OP_MUL;
        ar_a  = '0;
        ar_b  = '0;
        unique case (cmd.uop)
            U_QDIV: begin ar_op = OP_DIV;  ar_a = mag6_f;              ar_b = den_a;        end
            U_SQRT: begin ar_op = OP_SQRT; ar_a = q_reg << FRAC_BITS;  ar_b = '0;           end
            U_TAU:  begin ar_op = OP_DIV;  ar_a = {2'b00, tt, 30'd0};  ar_b = 64'(dd);      end
            U_TAU2: begin ar_op = OP_MUL;  ar_a = 64'(tau_reg);        ar_b = 64'(tau_reg); end
            U_S: begin
                ar_op = OP_MUL;
                ar_a  = 64'(s_reg);
                ar_b  = S_COEF - {32'd0, tau_reg, 1'b0};
            end
            U_U:    begin ar_op = OP_MUL;  ar_a = 64'(tau_reg);  ar_b = TAU_ONE - 64'(tau_reg); end
            U_P:    begin ar_op = OP_MUL;  ar_a = 64'(s_reg);    ar_b = 64'(mag);    end
            U_VM:   begin ar_op = OP_MUL;  ar_a = mag6_f;        ar_b = 64'(u_reg);  end
            U_VD:   begin ar_op = OP_DIVP; ar_a = '0;            ar_b = 64'(dd);     end
            U_TT:   begin ar_op = OP_MUL;  ar_a = 64'(dd);       ar_b = 64'(dd);     end
            U_AM:   begin ar_op = OP_MUL;  ar_a = magf;          ar_b = 64'(emag);   end
            U_AD:   begin ar_op = OP_DIVP; ar_a = '0;            ar_b = tt_reg;      end
            default: ;
        endcase
    end

    assign ar_start = cmd.issue && is_arith(cmd.uop);

    cptp_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ar_start),
        .op      (ar_op),
        .a       (ar_a),
        .b       (ar_b),
        .done    (ar_done),
        .acc_hi  (ar_hi),
        .acc_lo  (ar_lo)
    );

    // Trajectory state: latch start, store durations, advance time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < AXES; i++) begin
                start_reg[i] <= '0;
                dur_reg[i]   <= '0;
                elap_reg[i]  <= '0;
            end
            running_reg <= 1'b0;
        end else begin
            if (cmd.issue && cmd.uop == U_LATCH) begin
                start_reg[ax] <= sat_s32({{2{mpos[33]}}, mpos});
                elap_reg[ax]  <= '0;
                running_reg   <= 1'b1;
            end
            if (cmd.issue && cmd.uop == U_WR) begin
                elap_reg[ax] <= elap_sum[32] ? 32'hFFFF_FFFF : elap_sum[31:0];
            end
            if (ar_done && cmd.uop == U_SQRT) begin
                dur_reg[ax] <= ((q_reg >> Q_LIM) != '0) ? 32'hFFFF_FFFF : ar_hi[31:0];
            end
        end
    end

    // Item capture, intermediate values and per-axis results
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_reg <= s_data;
            alld_reg <= 1'b1;
            for (int i = 0; i < NUM_AXES; i++) begin
                opos_reg[i] <= '0;
                ovel_reg[i] <= '0;
                oacc_reg[i] <= '0;
            end
        end
        if (cmd.issue && cmd.uop == U_WR) begin
            if (active) begin
                alld_reg <= 1'b0;
            end else begin
                opos_reg[ax] <= tgt;
            end
        end
        if (ar_done) begin
            unique case (cmd.uop)
                U_QDIV: q_reg   <= ar_lo;
                U_TAU:  tau_reg <= ar_lo[30:0];
                U_TAU2: s_reg   <= ar_lo[60:30];
                U_S:    s_reg   <= ar_lo[60:30];
                U_U:    u_reg   <= ar_lo[60:30];
                U_P:    opos_reg[ax] <= sat_s32(pos_sum);
                U_VD:   ovel_reg[ax] <= signed_mag(neg, ar_lo >> 30);
                U_TT:   tt_reg  <= ar_lo;
                U_AD:   oacc_reg[ax] <= signed_mag(neg ^ eneg, ar_lo >> ACC_SH);
                default: ;
            endcase
        end
        // Load the output register
        if (cmd.push) begin
            m_data_reg.pos_x    <= opos_reg[0];
            m_data_reg.pos_y    <= opos_reg[1];
            m_data_reg.pos_z    <= opos_reg[2];
            m_data_reg.vel_x    <= ovel_reg[0];
            m_data_reg.vel_y    <= ovel_reg[1];
            m_data_reg.vel_z    <= ovel_reg[2];
            m_data_reg.acc_x    <= oacc_reg[0];
            m_data_reg.acc_y    <= oacc_reg[1];
            m_data_reg.acc_z    <= oacc_reg[2];
            m_data_reg.all_done <= running_reg & alld_reg;
        end
    end

    assign m_data          = m_data_reg;
    assign stat.arith_done = ar_done;
    assign stat.active     = active;
    assign stat.running    = running_reg;

endmodule

[rtl/cptp_ctrl.sv]
// ----------------------------------------------------------------------------
// cptp_ctrl
// Controller: accepts items, walks the per-axis step sequence, waits on the
// arithmetic unit and hands finished results to the output register.
// ----------------------------------------------------------------------------
`include "cubic_point_to_point_trajectory_core_assert.svh"
module cptp_ctrl #(
    parameter int AXES = cptp_pkg::AXES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_func,
    output logic                m_valid,
    input  logic                m_ready,
    output cptp_pkg::ctrl_cmd_t cmd,
    input  cptp_pkg::dp_stat_t  stat
);
    import cptp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_PUSH  = 4'b1000
    } state_t;

    localparam logic [AXIS_W-1:0] LAST_AX = AXIS_W'(AXES - 1);

    state_t            state_reg, state_next;
    uop_t              uop_reg, uop_next, nx_uop;
    logic [AXIS_W-1:0] axis_reg, axis_next, nx_axis;
    logic              m_valid_reg, m_valid_next;
    logic              nx_push, last;

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign cmd.accept = s_valid & s_ready;
    assign cmd.push   = (state_reg == ST_PUSH) && (!m_valid_reg || m_ready);
    assign cmd.issue  = (state_reg == ST_ISSUE);
    assign cmd.uop    = uop_reg;
    assign cmd.axis   = axis_reg;

    // Step sequence
    always_comb begin
        nx_uop  = uop_reg;
        nx_axis = axis_reg;
        nx_push = 1'b0;
        last    = (axis_reg == LAST_AX);
        unique case (uop_reg)
            U_LATCH: nx_uop = U_QDIV;
            U_QDIV:  nx_uop = U_SQRT;
            U_SQRT: begin
                if (last) begin
                    nx_uop  = U_CHECK;
                    nx_axis = '0;
                end else begin
                    nx_uop  = U_LATCH;
                    nx_axis = axis_reg + 1'b1;
                end
            end
            U_CHECK: nx_uop = stat.active ? U_TAU : U_WR;
            U_TAU:   nx_uop = U_TAU2;
            U_TAU2:  nx_uop = U_S;
            U_S:     nx_uop = U_U;
            U_U:     nx_uop = U_P;
            U_P:     nx_uop = U_VM;
            U_VM:    nx_uop = U_VD;
            U_VD:    nx_uop = U_TT;
            U_TT:    nx_uop = U_AM;
            U_AM:    nx_uop = U_AD;
            U_AD:    nx_uop = U_WR;
            U_WR: begin
                if (last) begin
                    nx_push = 1'b1;
                end else begin
                    nx_uop  = U_CHECK;
                    nx_axis = axis_reg + 1'b1;
                end
            end
            default: nx_push = 1'b1;
        endcase
    end

    // State transitions
    always_comb begin
        state_next = state_reg;
        uop_next   = uop_reg;
        axis_next  = axis_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.accept) begin
                    axis_next = '0;
                    if (s_func) begin
                        uop_next   = U_LATCH;
                        state_next = ST_ISSUE;
                    end else if (stat.running) begin
                        uop_next   = U_CHECK;
                        state_next = ST_ISSUE;
                    end else begin
                        state_next = ST_PUSH;
                    end
                end
            end
            ST_ISSUE: begin
                if (is_arith(uop_reg)) begin
                    state_next = ST_WAIT;
                end else if (nx_push) begin
                    state_next = ST_PUSH;
                end else begin
                    uop_next  = nx_uop;
                    axis_next = nx_axis;
                end
            end
            ST_WAIT: begin
                if (stat.arith_done) begin
                    uop_next   = nx_uop;
                    axis_next  = nx_axis;
                    state_next = ST_ISSUE;
                end
            end
            ST_PUSH: begin
                if (cmd.push) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold the result until taken
    always_comb begin
        if (cmd.push) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            uop_reg     <= U_LATCH;
            axis_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            uop_reg     <= uop_next;
            axis_reg    <= axis_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `CPTP_ASSERT(a_done_in_wait, aclk, aresetn, stat.arith_done |-> state_reg == ST_WAIT)
    `CPTP_ASSERT_NEXT(a_push_valid, aclk, aresetn, cmd.push, m_valid_reg)
    `CPTP_ASSERT_NEXT(a_accept_busy, aclk, aresetn, cmd.accept, !s_ready)

endmodule

[rtl/cubic_point_to_point_trajectory_core.sv]
// ----------------------------------------------------------------------------
// cubic_point_to_point_trajectory_core
// Three-axis cubic time-scaled setpoint generator with an APB register port.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one item per control tick. func=1 restarts the move
//   from the measured position, func=0 steps the running move. Each item
//   yields exactly one result item on m_* (position, velocity, acceleration
//   per axis, and all_done).
//   Work per item: a restart first runs one divide and one square root per
//   axis; then each axis still in motion takes ten multiply/divide passes,
//   and each axis holding its target skips them. All of it goes through one
//   shared bit-serial arithmetic unit, so one item is in work at a time.
//   The result sits in an output register; the next item is accepted while
//   it waits. If the receiver stalls, the finished item holds in the
//   sequencer until the output register frees up.
//   Reset clears the trajectory (outputs zero until the first restart) and
//   returns registers to target 0, peak acceleration 1.0, tick 0.01 s.
//   Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module cubic_point_to_point_trajectory_core #(
    parameter int AXES      = cptp_pkg::AXES_DEF,
    parameter int FRAC_BITS = cptp_pkg::FRAC_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  cptp_pkg::in_item_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output cptp_pkg::out_item_t         m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cptp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import cptp_pkg::*;

    cfg_t      cfg;
    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    cptp_regs #(
        .FRAC_BITS (FRAC_BITS)
    ) u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cptp_ctrl #(
        .AXES (AXES)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_data.func),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    cptp_dp #(
        .AXES      (AXES),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .cfg     (cfg),
        .s_data  (s_data),
        .m_data  (m_data)
    );

endmodule
